@@ hdl/mscg_pkg.sv @@
// Shared types and constants of the multi-stop color gradient block.
`timescale 1ns / 1ps
package mscg_pkg;

  localparam int POS_W = 24;
  localparam int CH_W  = 8;
  localparam int COL_W = 4 * CH_W;
  localparam int ENT_W = POS_W + COL_W;
  localparam int T_W   = 32;
  localparam int N_W   = T_W + 2;
  localparam int Q_W   = 8;
  localparam int STEP_W = 3;

  localparam logic [1:0] ACT_SET    = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_SET_FIRST,
    OP_SCAN_NEXT,
    OP_OVERWRITE,
    OP_INS_START,
    OP_SH_RD,
    OP_SH_WR,
    OP_INS_WR,
    OP_LK_NEXT,
    OP_LK_HIT,
    OP_MUL,
    OP_NUM,
    OP_DIV,
    OP_RES_EMPTY,
    OP_RES_FULL,
    OP_RES_RDATA,
    OP_RES_Q,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic [1:0] act;
    logic       count_zero;
    logic       full;
    logic       idx_last;
    logic       pos_eq;
    logic       pos_lt;
    logic       v_le;
    logic       v_lt_rd;
    logic       k_eq_idx;
    logic       div_last;
    logic       out_busy;
  } dp_status_t;

endpackage

@@ hdl/mscg_if.sv @@
// Stream interfaces for the item and result channels.
`timescale 1ns / 1ps
interface mscg_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [23:0] lookup_value;
  logic signed [23:0] stop_position;
  logic [7:0]         stop_red;
  logic [7:0]         stop_green;
  logic [7:0]         stop_blue;
  logic [7:0]         stop_alpha;
  modport source (output valid, action, lookup_value, stop_position, stop_red, stop_green,
                  stop_blue, stop_alpha, input ready);
  modport sink (input valid, action, lookup_value, stop_position, stop_red, stop_green,
                stop_blue, stop_alpha, output ready);
endinterface

interface mscg_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic [1:0] status;
  modport source (output valid, out_red, out_green, out_blue, out_alpha, status,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, status,
                output ready);
endinterface

@@ hdl/multi_stop_color_gradient_top.sv @@
// Top level of the multi-stop color gradient block.
//  channel  dir  beat
//  item     in   action, lookup_value, stop_position, stop RGBA
//  result   out  out RGBA, status
// Set: the stops are compared in turn, then each later stop is shifted up one place.
// Lookup: the stop scan runs over the single RAM read port, then the 8-step restoring
// divider forms the color. Clear resets the stop count.
// Reset clears the stop count; the stop RAM needs no clearing.
// A finished beat waits in the result register; a new item is taken meanwhile.
`timescale 1ns / 1ps
module multi_stop_color_gradient_top
  import mscg_pkg::*;
#(
  parameter int MAX_STOPS = 16
) (
  input logic           clk,
  input logic           rst,
  mscg_item_if.sink     item,
  mscg_result_if.source result
);
  dp_op_t     op;
  dp_status_t st;

  mscg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item.valid),
    .item_ready(item.ready),
    .st        (st),
    .op        (op)
  );

  mscg_datapath #(.MAX_STOPS(MAX_STOPS)) u_dp (
    .clk   (clk),
    .rst   (rst),
    .op    (op),
    .st    (st),
    .item  (item),
    .result(result)
  );
endmodule

@@ hdl/mscg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mscg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/mscg_ctrl.sv @@
// Sequencer for set, lookup and clear items.
`timescale 1ns / 1ps
module mscg_ctrl
  import mscg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  dp_status_t st,
  output dp_op_t     op
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SCMP, S_INS, S_SHIFT, S_SHWR, S_LSCAN, S_MUL, S_NUM, S_DIV,
    S_RESQ, S_DONE
  } state_t;

  state_t state, state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    op = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          op = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        case (st.act)
          ACT_CLEAR: op = OP_CLEAR;
          ACT_SET: begin
            if (st.count_zero) begin
              op = OP_SET_FIRST;
            end else begin
              state_next = S_SCMP;
            end
          end
          ACT_LOOKUP: begin
            if (st.count_zero) begin
              op = OP_RES_EMPTY;
            end else if (st.v_le || st.idx_last) begin
              op = OP_RES_RDATA;
            end else begin
              op = OP_LK_NEXT;
              state_next = S_LSCAN;
            end
          end
          default: op = OP_NONE;
        endcase
      end
      S_SCMP: begin
        if (st.pos_eq) begin
          op = OP_OVERWRITE;
          state_next = S_DONE;
        end else if (st.pos_lt) begin
          op = OP_SCAN_NEXT;
          if (st.idx_last) begin
            state_next = S_INS;
          end
        end else begin
          state_next = S_INS;
        end
      end
      S_INS: begin
        if (st.full) begin
          op = OP_RES_FULL;
          state_next = S_DONE;
        end else begin
          op = OP_INS_START;
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (st.k_eq_idx) begin
          op = OP_INS_WR;
          state_next = S_DONE;
        end else begin
          op = OP_SH_RD;
          state_next = S_SHWR;
        end
      end
      S_SHWR: begin
        op = OP_SH_WR;
        state_next = S_SHIFT;
      end
      S_LSCAN: begin
        if (st.v_lt_rd) begin
          op = OP_LK_HIT;
          state_next = S_MUL;
        end else if (st.idx_last) begin
          op = OP_RES_RDATA;
          state_next = S_DONE;
        end else begin
          op = OP_LK_NEXT;
        end
      end
      S_MUL: begin
        op = OP_MUL;
        state_next = S_NUM;
      end
      S_NUM: begin
        op = OP_NUM;
        state_next = S_DIV;
      end
      S_DIV: begin
        op = OP_DIV;
        if (st.div_last) begin
          state_next = S_RESQ;
        end
      end
      S_RESQ: begin
        op = OP_RES_Q;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          op = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

@@ hdl/mscg_datapath.sv @@
// Stop table, search registers, interpolation and serial divider.
`timescale 1ns / 1ps
module mscg_datapath
  import mscg_pkg::*;
#(
  parameter int MAX_STOPS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  dp_op_t       op,
  output dp_status_t   st,
  mscg_item_if.sink    item,
  mscg_result_if.source result
);
  localparam int AW = $clog2(MAX_STOPS);
  localparam int CW = $clog2(MAX_STOPS + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_STOPS);

  logic [1:0]              act;
  logic signed [POS_W-1:0] pos, val;
  logic [COL_W-1:0]        col;
  logic [CW-1:0]           count, idx, k;
  logic [ENT_W-1:0]        prev, cur;
  logic [POS_W-1:0]        span;
  logic [T_W-1:0]          tsum [4];
  logic [N_W-1:0]          num [4];
  logic [Q_W-1:0]          quo [4];
  logic [STEP_W-1:0]       step;
  logic [COL_W-1:0]        res_c;
  logic [1:0]              res_s;

  logic                    we;
  logic [AW-1:0]           waddr, raddr;
  logic [ENT_W-1:0]        wdata, rdata;
  logic signed [POS_W-1:0] rd_pos;
  logic [CW-1:0]           idx_inc, k_dec;

  assign rd_pos  = rdata[ENT_W-1 -: POS_W];
  assign idx_inc = idx + CW'(1);
  assign k_dec   = k - CW'(1);

  always_comb begin
    we = 1'b0;
    waddr = idx[AW-1:0];
    wdata = {pos, col};
    raddr = idx[AW-1:0];
    case (op)
      OP_LOAD:      raddr = '0;
      OP_SET_FIRST: begin
        we = 1'b1;
        waddr = '0;
      end
      OP_OVERWRITE, OP_INS_WR: we = 1'b1;
      OP_SCAN_NEXT, OP_LK_NEXT: raddr = idx_inc[AW-1:0];
      OP_SH_RD: raddr = k_dec[AW-1:0];
      OP_SH_WR: begin
        we = 1'b1;
        waddr = k[AW-1:0];
        wdata = rdata;
      end
      default: ;
    endcase
  end

  mscg_ram #(.WIDTH(ENT_W), .DEPTH(MAX_STOPS)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign st.act        = act;
  assign st.count_zero = (count == '0);
  assign st.full       = (count == MAX_C);
  assign st.idx_last   = (idx == count - CW'(1));
  assign st.pos_eq     = (rd_pos == pos);
  assign st.pos_lt     = (rd_pos < pos);
  assign st.v_le       = (val <= rd_pos);
  assign st.v_lt_rd    = (val < rd_pos);
  assign st.k_eq_idx   = (k == idx);
  assign st.div_last   = (step == '0);
  assign st.out_busy   = result.valid && !result.ready;

  logic signed [POS_W-1:0] p_lo, p_hi;
  logic [POS_W-1:0]        w_lo, w_hi;
  logic [N_W-1:0]          dsh;
  assign p_lo = prev[ENT_W-1 -: POS_W];
  assign p_hi = cur[ENT_W-1 -: POS_W];
  assign w_hi = POS_W'(val - p_lo);
  assign w_lo = POS_W'(p_hi - val);
  assign dsh  = N_W'({span, 1'b0}) << step;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      result.valid <= 1'b0;
    end else begin
      if (op == OP_EMIT) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      case (op)
        OP_LOAD: begin
          act <= item.action;
          pos <= item.stop_position;
          val <= item.lookup_value;
          col <= {item.stop_alpha, item.stop_blue, item.stop_green, item.stop_red};
          idx <= '0;
          res_c <= '0;
          res_s <= ST_OK;
        end
        OP_CLEAR:     count <= '0;
        OP_SET_FIRST: count <= CW'(1);
        OP_SCAN_NEXT: idx <= idx_inc;
        OP_INS_START: k <= count;
        OP_SH_WR:     k <= k_dec;
        OP_INS_WR:    count <= count + CW'(1);
        OP_LK_NEXT: begin
          prev <= rdata;
          idx <= idx_inc;
        end
        OP_LK_HIT: cur <= rdata;
        OP_MUL: begin
          span <= POS_W'(p_hi - p_lo);
          for (int c = 0; c < 4; c++) begin
            tsum[c] <= T_W'(prev[c*CH_W +: CH_W]) * T_W'(w_lo) +
                       T_W'(cur[c*CH_W +: CH_W]) * T_W'(w_hi);
          end
        end
        OP_NUM: begin
          step <= STEP_W'(Q_W - 1);
          for (int c = 0; c < 4; c++) begin
            num[c] <= N_W'({tsum[c], 1'b0}) + N_W'(span);
            quo[c] <= '0;
          end
        end
        OP_DIV: begin
          step <= step - STEP_W'(1);
          for (int c = 0; c < 4; c++) begin
            if (num[c] >= dsh) begin
              num[c] <= num[c] - dsh;
              quo[c][step] <= 1'b1;
            end
          end
        end
        OP_RES_EMPTY: res_s <= ST_EMPTY;
        OP_RES_FULL:  res_s <= ST_FULL;
        OP_RES_RDATA: res_c <= rdata[COL_W-1:0];
        OP_RES_Q:     res_c <= {quo[3], quo[2], quo[1], quo[0]};
        OP_EMIT: begin
          result.out_red <= res_c[7:0];
          result.out_green <= res_c[15:8];
          result.out_blue <= res_c[23:16];
          result.out_alpha <= res_c[31:24];
          result.status <= res_s;
        end
        default: ;
      endcase
    end
  end
endmodule

@@ hdl/mscg_checker.sv @@
// Port-level checks of the gradient block and their binding.
`timescale 1ns / 1ps
module mscg_checker
  import mscg_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [7:0] r,
  input logic [7:0] g,
  input logic [7:0] b,
  input logic [7:0] a
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("unknown status code");
  a_errcol: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY || status == ST_FULL) |-> (r | g | b | a) == 8'd0)
    else $error("color on error result");
endmodule

bind multi_stop_color_gradient_top mscg_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .in_valid (item.valid),
  .in_ready (item.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .status   (result.status),
  .r        (result.out_red),
  .g        (result.out_green),
  .b        (result.out_blue),
  .a        (result.out_alpha)
);
